@@ design/bounded_undo_redo_history_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded undo/redo history unit
// Each macro expands to one labeled concurrent assertion on i_clk, disabled
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNDO_REDO_HISTORY_UNIT_ASSERT_SVH
`define BOUNDED_UNDO_REDO_HISTORY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BUR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bounded undo/redo history check failed");

// The consequent must hold in the cycle after the antecedent.
`define BUR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bounded undo/redo history check failed");

`endif

@@ design/bur_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded undo/redo history package
// Sizes, opcodes, controller states and the command struct shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bur_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int ENTRY_WIDTH   = 64;
    localparam int VALUE_W       = 64;
    localparam int COUNT_OUT_W   = 6;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_COMMIT = 2'd0,
        OP_UNDO   = 2'd1,
        OP_REDO   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    typedef struct packed {
        logic start;
        logic load;
    } t_cmd;

endpackage

@@ design/bur_ram.sv @@
// ----------------------------------------------------------------------------
// Bounded undo/redo history stack memory
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module bur_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bur_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded undo/redo history controller
// Sequences each operation through an update cycle and a read cycle and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module bur_ctrl
    import bur_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd.start = 1'b0;
        o_cmd.load  = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/bur_dp.sv @@
// ----------------------------------------------------------------------------
// Bounded undo/redo history datapath
// Two ring stacks with base and depth registers, their memories, and the
// result register.
// ----------------------------------------------------------------------------
module bur_dp
    import bur_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [1:0]             i_opcode,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   o_ok,
    output logic [VALUE_W-1:0]     o_working,
    output logic [COUNT_OUT_W-1:0] o_undo_count,
    output logic [COUNT_OUT_W-1:0] o_redo_count
);

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(HISTORY_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(HISTORY_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [PTR_W-1:0]       r_undo_base, n_undo_base, r_redo_base, n_redo_base;
    logic [CNT_W-1:0]       r_undo_depth, n_undo_depth, r_redo_depth, n_redo_depth;
    logic                   r_ok, n_ok, r_pop, n_pop, r_from_redo, n_from_redo;
    logic [VALUE_W-1:0]     r_value;
    logic                   r_out_ok;
    logic [VALUE_W-1:0]     r_out_working;
    logic [COUNT_OUT_W-1:0] r_out_undo, r_out_redo;

    logic                   undo_full, redo_full;
    logic [PTR_W-1:0]       undo_push_slot, redo_push_slot;
    logic [PTR_W-1:0]       undo_push_base, redo_push_base;
    logic [CNT_W-1:0]       undo_push_depth, redo_push_depth;
    logic [PTR_W-1:0]       undo_pop_slot, redo_pop_slot;

    logic                   undo_we, undo_re, redo_we, redo_re;
    logic [PTR_W-1:0]       undo_waddr, undo_raddr, redo_waddr, redo_raddr;
    logic [ENTRY_WIDTH-1:0] wdata, undo_rdata, redo_rdata;

    assign wdata = i_value[ENTRY_WIDTH-1:0];

    assign undo_full       = r_undo_depth == CNT_W'(HISTORY_DEPTH);
    assign undo_push_slot  = undo_full ? r_undo_base : ptr_add(r_undo_base, r_undo_depth);
    assign undo_push_base  = undo_full ? ptr_add(r_undo_base, CNT_W'(1)) : r_undo_base;
    assign undo_push_depth = undo_full ? r_undo_depth : r_undo_depth + CNT_W'(1);
    assign undo_pop_slot   = ptr_add(r_undo_base, r_undo_depth - CNT_W'(1));

    assign redo_full       = r_redo_depth == CNT_W'(HISTORY_DEPTH);
    assign redo_push_slot  = redo_full ? r_redo_base : ptr_add(r_redo_base, r_redo_depth);
    assign redo_push_base  = redo_full ? ptr_add(r_redo_base, CNT_W'(1)) : r_redo_base;
    assign redo_push_depth = redo_full ? r_redo_depth : r_redo_depth + CNT_W'(1);
    assign redo_pop_slot   = ptr_add(r_redo_base, r_redo_depth - CNT_W'(1));

    always_comb begin
        n_undo_base  = r_undo_base;
        n_undo_depth = r_undo_depth;
        n_redo_base  = r_redo_base;
        n_redo_depth = r_redo_depth;
        n_ok         = r_ok;
        n_pop        = r_pop;
        n_from_redo  = r_from_redo;
        undo_we      = 1'b0;
        undo_re      = 1'b0;
        redo_we      = 1'b0;
        redo_re      = 1'b0;
        undo_waddr   = undo_push_slot;
        redo_waddr   = redo_push_slot;
        undo_raddr   = undo_pop_slot;
        redo_raddr   = redo_pop_slot;
        if (i_cmd.start) begin
            n_ok        = 1'b0;
            n_pop       = 1'b0;
            n_from_redo = 1'b0;
            unique case (t_opcode'(i_opcode))
                OP_COMMIT: begin
                    undo_we      = 1'b1;
                    n_undo_base  = undo_push_base;
                    n_undo_depth = undo_push_depth;
                    n_redo_base  = '0;
                    n_redo_depth = '0;
                    n_ok         = 1'b1;
                end
                OP_UNDO: begin
                    if (r_undo_depth != '0) begin
                        redo_we      = 1'b1;
                        n_redo_base  = redo_push_base;
                        n_redo_depth = redo_push_depth;
                        undo_re      = 1'b1;
                        n_undo_depth = r_undo_depth - CNT_W'(1);
                        n_ok         = 1'b1;
                        n_pop        = 1'b1;
                    end
                end
                OP_REDO: begin
                    if (r_redo_depth != '0) begin
                        undo_we      = 1'b1;
                        n_undo_base  = undo_push_base;
                        n_undo_depth = undo_push_depth;
                        redo_re      = 1'b1;
                        n_redo_depth = r_redo_depth - CNT_W'(1);
                        n_ok         = 1'b1;
                        n_pop        = 1'b1;
                        n_from_redo  = 1'b1;
                    end
                end
                OP_UNUSED: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undo_base  <= '0;
            r_undo_depth <= '0;
            r_redo_base  <= '0;
            r_redo_depth <= '0;
        end else begin
            r_undo_base  <= n_undo_base;
            r_undo_depth <= n_undo_depth;
            r_redo_base  <= n_redo_base;
            r_redo_depth <= n_redo_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok        <= n_ok;
        r_pop       <= n_pop;
        r_from_redo <= n_from_redo;
        if (i_cmd.start) begin
            r_value <= i_value;
        end
        if (i_cmd.load) begin
            r_out_ok   <= r_ok;
            r_out_undo <= COUNT_OUT_W'(r_undo_depth);
            r_out_redo <= COUNT_OUT_W'(r_redo_depth);
            if (!r_pop) begin
                r_out_working <= r_value;
            end else if (r_from_redo) begin
                r_out_working <= VALUE_W'(redo_rdata);
            end else begin
                r_out_working <= VALUE_W'(undo_rdata);
            end
        end
    end

    bur_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (ENTRY_WIDTH)
    ) u_undo_ram (
        .i_clk   (i_clk),
        .i_we    (undo_we),
        .i_waddr (undo_waddr),
        .i_wdata (wdata),
        .i_re    (undo_re),
        .i_raddr (undo_raddr),
        .o_rdata (undo_rdata)
    );

    bur_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (ENTRY_WIDTH)
    ) u_redo_ram (
        .i_clk   (i_clk),
        .i_we    (redo_we),
        .i_waddr (redo_waddr),
        .i_wdata (wdata),
        .i_re    (redo_re),
        .i_raddr (redo_raddr),
        .o_rdata (redo_rdata)
    );

    assign o_ok         = r_out_ok;
    assign o_working    = r_out_working;
    assign o_undo_count = r_out_undo;
    assign o_redo_count = r_out_redo;

endmodule

@@ design/bounded_undo_redo_history_unit.sv @@
// ----------------------------------------------------------------------------
// Bounded undo/redo history unit
// Two bounded ring stacks of entries with commit, undo and redo operations.
//
//   Channel  Handshake                 Fields
//   input    i_in_valid / o_in_ready   i_opcode, i_value
//   output   o_out_valid / i_out_ready o_ok, o_working, o_undo_count,
//                                      o_redo_count
//
// Each operation runs in two steps: the pointer update and the stack memory
// read of the popped entry, then the load of the result register.
// A new beat is accepted while a finished result still waits to be taken.
// A stalled output holds the controller in its read cycle until the result
// register is free; the read data stays registered meanwhile.
// Reset clears both stacks at once; no clearing pass runs.
// ----------------------------------------------------------------------------
module bounded_undo_redo_history_unit
    import bur_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_opcode,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_ok,
    output logic [VALUE_W-1:0]     o_working,
    output logic [COUNT_OUT_W-1:0] o_undo_count,
    output logic [COUNT_OUT_W-1:0] o_redo_count
);

    t_cmd cmd;

    bur_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bur_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_ok         (o_ok),
        .o_working    (o_working),
        .o_undo_count (o_undo_count),
        .o_redo_count (o_redo_count)
    );

endmodule

@@ design/bur_checker.sv @@
// ----------------------------------------------------------------------------
// Bounded undo/redo history port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_undo_redo_history_unit_assert.svh"

module bur_checker
    import bur_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic                   o_ok,
    input logic [VALUE_W-1:0]     o_working,
    input logic [COUNT_OUT_W-1:0] o_undo_count,
    input logic [COUNT_OUT_W-1:0] o_redo_count
);

    logic [VALUE_W+2*COUNT_OUT_W:0] out_beat;

    assign out_beat = {o_ok, o_working, o_undo_count, o_redo_count};

    `BUR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_beat))
    `BUR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `BUR_ASSERT_SAME(a_result_after_read, $rose(o_out_valid), $past(!o_in_ready))

endmodule

bind bounded_undo_redo_history_unit bur_checker u_bur_checker (.*);

@@ bench/bounded_undo_redo_history_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded undo/redo history unit testbench
// Drives commit, undo, redo and unused operations through the input channel,
// tracks both history rings in a scoreboard and checks every result beat,
// field by field, against the predicted working value and stack counts.
// Directed cases first, then random runs of edits under varying back-pressure.
// ----------------------------------------------------------------------------
module bounded_undo_redo_history_unit_tb;
    import bur_pkg::*;

    localparam int UNDO_SIDE = 0;
    localparam int REDO_SIDE = 1;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_GAP = 24;
    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    typedef struct {
        logic                   ok;
        logic [VALUE_W-1:0]     working;
        logic [COUNT_OUT_W-1:0] undo_cnt;
        logic [COUNT_OUT_W-1:0] redo_cnt;
    } t_edit_result;

    class history_scoreboard;
        logic [ENTRY_WIDTH-1:0] ring [2][HISTORY_DEPTH];
        int base [2];
        int depth [2];
        t_edit_result expected [$];
        int errors;

        function void push_entry(int side, logic [VALUE_W-1:0] v);
            int slot;
            if (depth[side] == HISTORY_DEPTH) begin
                slot = base[side];
                base[side] = (base[side] + 1) % HISTORY_DEPTH;
            end else begin
                slot = (base[side] + depth[side]) % HISTORY_DEPTH;
                depth[side]++;
            end
            ring[side][slot] = v[ENTRY_WIDTH-1:0];
        endfunction

        function logic [VALUE_W-1:0] pop_entry(int side);
            depth[side]--;
            return VALUE_W'(ring[side][(base[side] + depth[side]) % HISTORY_DEPTH]);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_accepted(t_opcode op, logic [VALUE_W-1:0] value);
            t_edit_result r;
            r.ok = 1'b0;
            r.working = value;
            case (op)
                OP_COMMIT: begin
                    push_entry(UNDO_SIDE, value);
                    depth[REDO_SIDE] = 0;
                    base[REDO_SIDE] = 0;
                    r.ok = 1'b1;
                end
                OP_UNDO: begin
                    if (depth[UNDO_SIDE] != 0) begin
                        push_entry(REDO_SIDE, value);
                        r.working = pop_entry(UNDO_SIDE);
                        r.ok = 1'b1;
                    end
                end
                OP_REDO: begin
                    if (depth[REDO_SIDE] != 0) begin
                        push_entry(UNDO_SIDE, value);
                        r.working = pop_entry(REDO_SIDE);
                        r.ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.undo_cnt = COUNT_OUT_W'(depth[UNDO_SIDE]);
            r.redo_cnt = COUNT_OUT_W'(depth[REDO_SIDE]);
            expected.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("ERROR %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic ok, logic [VALUE_W-1:0] working,
                          logic [COUNT_OUT_W-1:0] undo_cnt,
                          logic [COUNT_OUT_W-1:0] redo_cnt);
            t_edit_result e;
            if (expected.size() == 0) begin
                report_mismatch("result beat with no operation outstanding");
                return;
            end
            e = expected.pop_front();
            if (ok !== e.ok)
                report_mismatch($sformatf("ok %b, expected %b", ok, e.ok));
            if (working !== e.working)
                report_mismatch($sformatf("working %h, expected %h", working, e.working));
            if (undo_cnt !== e.undo_cnt)
                report_mismatch($sformatf("undo count %0d, expected %0d",
                                          undo_cnt, e.undo_cnt));
            if (redo_cnt !== e.redo_cnt)
                report_mismatch($sformatf("redo count %0d, expected %0d",
                                          redo_cnt, e.redo_cnt));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_opcode = OP_UNUSED;
    logic [VALUE_W-1:0]     i_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_ok;
    logic [VALUE_W-1:0]     o_working;
    logic [COUNT_OUT_W-1:0] o_undo_count;
    logic [COUNT_OUT_W-1:0] o_redo_count;

    history_scoreboard sb = new;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    bounded_undo_redo_history_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ok         (o_ok),
        .o_working    (o_working),
        .o_undo_count (o_undo_count),
        .o_redo_count (o_redo_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // The receiver checks each beat taken at an edge, then picks its next ready.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_ok, o_working, o_undo_count, o_redo_count);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(t_opcode op, logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_value <= value;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_accepted(op, value);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return '0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_directed();
        send_item(OP_UNUSED, '0);
        send_item(OP_UNDO, ALL_ONES);
        send_item(OP_REDO, '0);
        send_item(OP_COMMIT, '0);
        send_item(OP_COMMIT, ALL_ONES);
        send_item(OP_COMMIT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_COMMIT, 64'h5555_5555_5555_5555);
        send_item(OP_UNUSED, ALL_ONES);
        send_item(OP_UNDO, 64'h0123_4567_89AB_CDEF);
        send_item(OP_UNDO, ALL_ONES);
        send_item(OP_REDO, '0);
        send_item(OP_REDO, 64'h8000_0000_0000_0001);
        send_item(OP_REDO, '0);
        send_item(OP_UNDO, 64'hFEDC_BA98_7654_3210);
        send_item(OP_COMMIT, 64'h0000_0000_FFFF_FFFF);
        send_item(OP_REDO, 64'hFFFF_FFFF_0000_0000);
        repeat (5) send_item(OP_UNDO, pick_value());
        repeat (3) send_item(OP_REDO, pick_value());
    endtask

    // Runs of edits: commit bursts that overflow the ring, undo and redo runs
    // that walk the stacks down to empty, alternating undo/redo runs, and a share of single random items.
    task automatic run_random(int n_items);
        int sent;
        int kind;
        int len;
        t_opcode op;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                len = $urandom_range(33, 40);
                op = OP_COMMIT;
            end else if (kind < 35) begin
                len = $urandom_range(1, 8);
                op = OP_COMMIT;
            end else if (kind < 55) begin
                len = $urandom_range(1, 12);
                op = OP_UNDO;
            end else if (kind < 68) begin
                len = $urandom_range(1, 12);
                op = OP_REDO;
            end else if (kind < 78) begin
                len = $urandom_range(20, 40);
                op = OP_UNDO;
            end else begin
                len = 1;
                op = t_opcode'($urandom_range(3));
            end
            if (kind >= 78 && kind < 88) begin
                len = $urandom_range(2, 10);
                for (int k = 0; k < len; k++)
                    send_item((k % 2 == 0) ? OP_UNDO : OP_REDO, pick_value());
            end else begin
                for (int k = 0; k < len; k++)
                    send_item(op, pick_value());
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 81;
        run_directed();
        run_random(300);
        hold_request = 1'b1;
        send_idle_pct = 0;
        run_random(40);
        send_idle_pct = 31;
        run_random(270);
        wait_drained();

        send_idle_pct = 81;
        recv_idle_pct = 31;
        run_random(610);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(610);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ bounded_undo_redo_history_unit.f @@
+incdir+design
design/bur_pkg.sv
design/bur_ram.sv
design/bur_ctrl.sv
design/bur_dp.sv
design/bounded_undo_redo_history_unit.sv
design/bur_checker.sv
bench/bounded_undo_redo_history_unit_tb.sv
